/* design/scbi_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, latencies and sideband types for the sine curve box hit test.
package scbi_pkg;

  // reduced phase, Q3.44, always below 2*pi
  localparam int PH_W = 47;
  localparam logic [PH_W-1:0] TWO_PI_Q44        = 47'h6487ED5110B4;
  localparam logic [PH_W-1:0] HALF_PI_Q44       = 47'h1921FB54442D;
  localparam logic [PH_W-1:0] PI_Q44            = 47'h3243F6A8885A;
  localparam logic [PH_W-1:0] THREE_HALF_PI_Q44 = 47'h4B65F1FDCC87;

  // sine magnitude, Q1.30, at most 1.0
  localparam int MAG_W = 31;
  localparam logic [MAG_W-1:0] ONE_Q30 = 31'h4000_0000;

  // Horner divisors and their reciprocals, scaled by 2^RECIP_SH
  localparam int HORNER_N = 6;
  localparam int RECIP_SH = 36;
  localparam logic [7:0] HDIV [HORNER_N] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [33:0] HRECIP [HORNER_N] = '{
    34'((64'd1 << RECIP_SH) / 64'd156),
    34'((64'd1 << RECIP_SH) / 64'd110),
    34'((64'd1 << RECIP_SH) / 64'd72),
    34'((64'd1 << RECIP_SH) / 64'd42),
    34'((64'd1 << RECIP_SH) / 64'd20),
    34'((64'd1 << RECIP_SH) / 64'd6)
  };

  // |phase| <= 2^62 < (2*pi << 17): 17 conditional subtractions
  localparam int RED_STEPS  = 17;
  localparam int REDUCE_LAT = RED_STEPS + 3;
  localparam int SIN_LAT    = 4 * HORNER_N + 4;
  // quotient of (sin << 16) / r
  localparam int NUM_W      = MAG_W + 16;
  localparam int DIV_LAT    = NUM_W;
  localparam int PIPE_LAT   = REDUCE_LAT + SIN_LAT + DIV_LAT + 2;

  typedef struct packed {
    logic signed [31:0] bottom;
    logic signed [31:0] top;
    logic [31:0]        r;
    logic               zpos;
    logic               zneg;
  } side_t;

  typedef struct packed {
    side_t sd;
    logic  has_max;
    logic  has_min;
  } side_b_t;

endpackage

/* design/scbi_reduce.sv */
`timescale 1ns / 1ps
// Phase product a*z and its non-negative remainder modulo 2*pi, fully pipelined.
module scbi_reduce (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          a,
  input  logic signed [31:0]          z,
  output logic signed [63:0]          phase,
  output logic [scbi_pkg::PH_W-1:0]   mod_ph
);
  import scbi_pkg::*;

  localparam int RW = 63;

  logic signed [63:0] prod_r;
  logic [RW-1:0]      abs_r;
  logic               neg_r;
  logic signed [63:0] ph1_r;
  logic [RW-1:0]      rem_r [RED_STEPS];
  logic               rneg_r [RED_STEPS];
  logic signed [63:0] rph_r [RED_STEPS];
  logic [PH_W-1:0]    mod_r;
  logic signed [63:0] pho_r;
  logic [PH_W-1:0]    remf;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * z;
      neg_r  <= prod_r[63];
      abs_r  <= prod_r[63] ? RW'(-prod_r) : RW'(prod_r);
      ph1_r  <= prod_r;
    end
  end

  // one restoring step per stage, largest multiple first
  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [RW-1:0] SUBV = RW'(TWO_PI_Q44) << (RED_STEPS - 1 - k);
    logic [RW-1:0]      rin;
    logic               nin;
    logic signed [63:0] pin;
    if (k == 0) begin : g_first
      assign rin = abs_r;
      assign nin = neg_r;
      assign pin = ph1_r;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign nin = rneg_r[k-1];
      assign pin = rph_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= (rin >= SUBV) ? rin - SUBV : rin;
        rneg_r[k] <= nin;
        rph_r[k]  <= pin;
      end
    end
  end

  assign remf = rem_r[RED_STEPS-1][PH_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mod_r <= (rneg_r[RED_STEPS-1] && remf != '0) ? TWO_PI_Q44 - remf : remf;
      pho_r <= rph_r[RED_STEPS-1];
    end
  end

  assign mod_ph = mod_r;
  assign phase  = pho_r;

endmodule

/* design/scbi_sin.sv */
`timescale 1ns / 1ps
// Quadrant fold and degree 13 Horner sine of a reduced phase, pipelined.
module scbi_sin (
  input  logic                         clk,
  input  logic                         en,
  input  logic [scbi_pkg::PH_W-1:0]    ph,
  output logic [scbi_pkg::MAG_W-1:0]   mag,
  output logic                         neg
);
  import scbi_pkg::*;

  localparam int HS = 4 * HORNER_N;

  typedef struct packed {
    logic [31:0]      x2;
    logic [MAG_W-1:0] us;
    logic             ng;
  } ctx_t;

  logic [PH_W-1:0]  u;
  logic             un;
  logic [MAG_W-1:0] us_r;
  logic             ng_r;
  ctx_t             c0_r;
  ctx_t             cx_r [HS];
  logic [31:0]      v_r  [HORNER_N];
  logic [31:0]      v1_r [HORNER_N];
  logic [31:0]      q0_r [HORNER_N];
  logic [31:0]      q1_r [HORNER_N];
  logic [31:0]      rm_r [HORNER_N];
  logic [MAG_W-1:0] t_r  [HORNER_N];
  logic [31:0]      fm_r;
  logic             fn_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;

  // fold into [0, pi/2] with a sign
  always_comb begin
    u  = ph;
    un = 1'b0;
    if (ph < HALF_PI_Q44) begin
      u  = ph;
      un = 1'b0;
    end else if (ph < PI_Q44) begin
      u  = PI_Q44 - ph;
      un = 1'b0;
    end else if (ph < THREE_HALF_PI_Q44) begin
      u  = ph - PI_Q44;
      un = 1'b1;
    end else begin
      u  = TWO_PI_Q44 - ph;
      un = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      us_r    <= MAG_W'(u >> 14);
      ng_r    <= un;
      c0_r.x2 <= 32'((64'(us_r) * 64'(us_r)) >> 30);
      c0_r.us <= us_r;
      c0_r.ng <= ng_r;
    end
  end

  for (genvar j = 0; j < HORNER_N; j++) begin : g_hor
    logic [MAG_W-1:0] tin;
    ctx_t             cin;
    logic [31:0]      d;
    if (j == 0) begin : g_first
      assign tin = ONE_Q30;
      assign cin = c0_r;
    end else begin : g_next
      assign tin = t_r[j-1];
      assign cin = cx_r[4*j-1];
    end
    assign d = q1_r[j] + ((rm_r[j] >= 32'(HDIV[j])) ? 32'd1 : 32'd0);
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[j]       <= 32'((64'(cin.x2) * 64'(tin)) >> 30);
        cx_r[4*j]    <= cin;
        q0_r[j]      <= 32'((66'(v_r[j]) * 66'(HRECIP[j])) >> RECIP_SH);
        v1_r[j]      <= v_r[j];
        cx_r[4*j+1]  <= cx_r[4*j];
        rm_r[j]      <= v1_r[j] - 32'(40'(q0_r[j]) * 40'(HDIV[j]));
        q1_r[j]      <= q0_r[j];
        cx_r[4*j+2]  <= cx_r[4*j+1];
        t_r[j]       <= (d >= 32'(ONE_Q30)) ? '0 : ONE_Q30 - MAG_W'(d);
        cx_r[4*j+3]  <= cx_r[4*j+2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fm_r  <= 32'((64'(cx_r[HS-1].us) * 64'(t_r[HORNER_N-1])) >> 30);
      fn_r  <= cx_r[HS-1].ng;
      mag_r <= (fm_r > 32'(ONE_Q30)) ? ONE_Q30 : MAG_W'(fm_r);
      neg_r <= fn_r;
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

/* design/scbi_div.sv */
`timescale 1ns / 1ps
// Restoring divider (mag << 16) / r, one quotient bit per stage.
module scbi_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [scbi_pkg::MAG_W-1:0]   mag,
  input  logic [31:0]                  r,
  input  logic                         neg_in,
  output logic [scbi_pkg::NUM_W-1:0]   quo,
  output logic                         neg_out
);
  import scbi_pkg::*;

  logic [NUM_W-1:0] n_r [DIV_LAT];
  logic [NUM_W-1:0] q_r [DIV_LAT];
  logic [31:0]      rem_r [DIV_LAT];
  logic [31:0]      d_r [DIV_LAT];
  logic             s_r [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_stg
    logic [NUM_W-1:0] nin;
    logic [NUM_W-1:0] qin;
    logic [31:0]      rin;
    logic [31:0]      din;
    logic             sin;
    logic [32:0]      sh;
    logic             ge;
    if (i == 0) begin : g_first
      assign nin = {mag, 16'd0};
      assign qin = '0;
      assign rin = '0;
      assign din = r;
      assign sin = neg_in;
    end else begin : g_next
      assign nin = n_r[i-1];
      assign qin = q_r[i-1];
      assign rin = rem_r[i-1];
      assign din = d_r[i-1];
      assign sin = s_r[i-1];
    end
    assign sh = {rin, nin[NUM_W-1]};
    assign ge = (sh >= {1'b0, din});
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]   <= nin << 1;
        q_r[i]   <= {qin[NUM_W-2:0], ge};
        rem_r[i] <= ge ? 32'(sh - {1'b0, din}) : 32'(sh);
        d_r[i]   <= din;
        s_r[i]   <= sin;
      end
    end
  end

  assign quo     = q_r[DIV_LAT-1];
  assign neg_out = s_r[DIV_LAT-1];

endmodule

/* design/sine_curve_box_intersect_top.sv */
`timescale 1ns / 1ps
// Top level of the sine curve versus Hough box hit test.
//
// Usage:
//  - Input channel in_*: one request per box/hit pair (box edges, hit z and r).
//    A request is taken on a clock edge where in_valid and in_ready are high.
//  - Result channel out_*: one bit per request, in request order, held with
//    out_valid until out_ready.
//  - Throughput: one request per cycle, sustained, while results drain.
//  - Depth: the pipeline depth comes from the 17 step modulo 2*pi reduction
//    of the phase, the six Horner steps of the sine (four stages each) and
//    the 47 stage restoring divider that forms sin / r.
//  - The pipeline moves as a whole; a two entry result queue sits behind it.
//    When the receiver stalls and the queue fills, in_ready drops and every
//    stage holds; nothing is lost or repeated.
//  - Reset (rst_n low, synchronous) clears the valid line and the queue;
//    datapath registers are not reset.
module sine_curve_box_intersect_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_box_left,
  input  logic signed [31:0] in_box_right,
  input  logic signed [31:0] in_box_bottom,
  input  logic signed [31:0] in_box_top,
  input  logic signed [31:0] in_hit_z,
  input  logic [31:0]        in_hit_r,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_in_box
);
  import scbi_pkg::*;

  localparam int TOT    = PIPE_LAT;
  localparam int LB_LEN = SIN_LAT + DIV_LAT - 2;
  // sideband tap aligned with the sine output / divider input
  localparam int R_TAP  = SIN_LAT - 3;

  // global stage enable: held only while the result queue is full
  logic             en;
  logic             acc;
  logic [TOT-1:0]   vld_r;
  side_t            s_in;
  side_t            sa_r [REDUCE_LAT];

  logic signed [63:0] pl, pr;
  logic [PH_W-1:0]    ml, mr;

  // extremum search, two stages after the reduction
  logic signed [63:0] x1_pl_r, x1_pr_r;
  logic [PH_W-1:0]    offmax, offmin;
  logic [PH_W-1:0]    x1_offmax_r, x1_offmin_r;
  side_t              x1_sd_r;
  logic signed [64:0] p0max, p0min;
  side_b_t            x2_r;
  side_b_t            sb_r [LB_LEN];

  logic [MAG_W-1:0] mag_l, mag_r;
  logic             sn_l, sn_r;
  logic [NUM_W-1:0] q_l, q_r;
  logic             dn_l, dn_r;

  // decision stages
  logic signed [31:0] bl_r, br_r;
  logic [63:0]        invp_r;
  side_b_t            f1_r;
  logic               hit_r;
  logic               hit;
  logic               inv_ok;

  // result queue
  logic       push, pop;
  logic [1:0] cnt_r, cnt_nxt;
  logic       h0_r, h0_nxt, h1_r, h1_nxt;

  function automatic logic signed [31:0] sat_b(input logic [NUM_W-1:0] q, input logic n);
    logic signed [31:0] res;
    if (n) begin
      res = (q > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
    end else begin
      res = (q > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    return res;
  endfunction

  assign en       = (cnt_r != 2'd2);
  assign in_ready = en;
  assign acc      = in_valid && en;

  // zero radius counts as the smallest radius
  assign s_in.bottom = in_box_bottom;
  assign s_in.top    = in_box_top;
  assign s_in.r      = (in_hit_r == '0) ? 32'd1 : in_hit_r;
  assign s_in.zpos   = !in_hit_z[31] && (in_hit_z != '0);
  assign s_in.zneg   = in_hit_z[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r[0] <= s_in;
      for (int i = 1; i < REDUCE_LAT; i++) begin
        sa_r[i] <= sa_r[i-1];
      end
    end
  end

  scbi_reduce u_red_l (
    .clk(clk), .en(en), .a(in_box_left), .z(in_hit_z), .phase(pl), .mod_ph(ml)
  );

  scbi_reduce u_red_r (
    .clk(clk), .en(en), .a(in_box_right), .z(in_hit_z), .phase(pr), .mod_ph(mr)
  );

  // offset from the left phase to the next target phase, upwards for z > 0,
  // downwards for z < 0
  always_comb begin
    if (sa_r[REDUCE_LAT-1].zpos) begin
      offmax = (HALF_PI_Q44 >= ml) ? HALF_PI_Q44 - ml : HALF_PI_Q44 + (TWO_PI_Q44 - ml);
      offmin = (THREE_HALF_PI_Q44 >= ml) ? THREE_HALF_PI_Q44 - ml
                                         : THREE_HALF_PI_Q44 + (TWO_PI_Q44 - ml);
    end else begin
      offmax = (ml >= HALF_PI_Q44) ? ml - HALF_PI_Q44 : ml + (TWO_PI_Q44 - HALF_PI_Q44);
      offmin = (ml >= THREE_HALF_PI_Q44) ? ml - THREE_HALF_PI_Q44
                                         : ml + (TWO_PI_Q44 - THREE_HALF_PI_Q44);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_pl_r     <= pl;
      x1_pr_r     <= pr;
      x1_offmax_r <= offmax;
      x1_offmin_r <= offmin;
      x1_sd_r     <= sa_r[REDUCE_LAT-1];
    end
  end

  assign p0max = x1_sd_r.zpos ? 65'(x1_pl_r) + $signed({18'd0, x1_offmax_r})
                              : 65'(x1_pl_r) - $signed({18'd0, x1_offmax_r});
  assign p0min = x1_sd_r.zpos ? 65'(x1_pl_r) + $signed({18'd0, x1_offmin_r})
                              : 65'(x1_pl_r) - $signed({18'd0, x1_offmin_r});

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r.sd      <= x1_sd_r;
      x2_r.has_max <= (x1_sd_r.zpos && (p0max < 65'(x1_pr_r))) ||
                      (x1_sd_r.zneg && (p0max > 65'(x1_pr_r)));
      x2_r.has_min <= (x1_sd_r.zpos && (p0min < 65'(x1_pr_r))) ||
                      (x1_sd_r.zneg && (p0min > 65'(x1_pr_r)));
      sb_r[0] <= x2_r;
      for (int i = 1; i < LB_LEN; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  scbi_sin u_sin_l (.clk(clk), .en(en), .ph(ml), .mag(mag_l), .neg(sn_l));
  scbi_sin u_sin_r (.clk(clk), .en(en), .ph(mr), .mag(mag_r), .neg(sn_r));

  scbi_div u_div_l (
    .clk(clk), .en(en), .mag(mag_l), .r(sb_r[R_TAP].sd.r), .neg_in(sn_l),
    .quo(q_l), .neg_out(dn_l)
  );

  scbi_div u_div_r (
    .clk(clk), .en(en), .mag(mag_r), .r(sb_r[R_TAP].sd.r), .neg_in(sn_r),
    .quo(q_r), .neg_out(dn_r)
  );

  // F1: saturate edge values, (bottom + 1) * r for the 1/r test
  always_ff @(posedge clk) begin
    if (en) begin
      bl_r   <= sat_b(q_l, dn_l);
      br_r   <= sat_b(q_r, dn_r);
      invp_r <= 64'($unsigned(sb_r[LB_LEN-1].sd.bottom) + 32'd1) *
                64'(sb_r[LB_LEN-1].sd.r);
      f1_r   <= sb_r[LB_LEN-1];
    end
  end

  // 1/r > bottom, with 1/r = 2^46 / r saturated to the largest positive value
  assign inv_ok = f1_r.sd.bottom[31] ||
                  (($unsigned(f1_r.sd.bottom) != 32'h7FFF_FFFF) &&
                   (invp_r <= (64'd1 << 46)));

  always_comb begin
    hit = 1'b0;
    if (bl_r >= f1_r.sd.bottom && bl_r <= f1_r.sd.top) begin
      hit = 1'b1;
    end else if (br_r >= f1_r.sd.bottom && br_r <= f1_r.sd.top) begin
      hit = 1'b1;
    end else if (bl_r < f1_r.sd.bottom && br_r > f1_r.sd.top) begin
      hit = 1'b1;
    end else if (bl_r > f1_r.sd.top && br_r < f1_r.sd.bottom) begin
      hit = 1'b1;
    end else begin
      if (bl_r < f1_r.sd.bottom && br_r < f1_r.sd.bottom && f1_r.has_max && inv_ok) begin
        hit = 1'b1;
      end
      // minimum: only the top edge is tested
      if (bl_r > f1_r.sd.bottom && br_r > f1_r.sd.bottom && f1_r.has_min &&
          !f1_r.sd.top[31]) begin
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit;
    end
  end

  // two entry result queue behind the pipeline
  assign push      = en && vld_r[TOT-1];
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_in_box = h0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    h0_nxt  = h0_r;
    h1_nxt  = h1_r;
    case ({push, pop})
      2'b10: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          h0_nxt = hit_r;
        end else begin
          h1_nxt = hit_r;
        end
      end
      2'b01: begin
        cnt_nxt = cnt_r - 2'd1;
        h0_nxt  = h1_r;
      end
      2'b11: begin
        if (cnt_r == 2'd1) begin
          h0_nxt = hit_r;
        end else begin
          h0_nxt = h1_r;
          h1_nxt = hit_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r <= h0_nxt;
    h1_r <= h1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while held");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count missed a push");

  a_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cnt_r == 2'd0) |=> (out_valid && out_in_box == $past(hit_r)))
    else $error("result not presented after push into empty queue");

endmodule
